// ===== rtl/point_pair_distance_metrics_assert.svh =====
// Assertion macros shared by the point pair distance RTL.
`ifndef POINT_PAIR_DISTANCE_METRICS_ASSERT_SVH
`define POINT_PAIR_DISTANCE_METRICS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ppdm_pkg.sv =====
// Widths and constants of the point pair distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

package ppdm_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int EUC_W     = (D2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W     = 2 * EUC_W;
  localparam int MANH_W    = COORD_W + 1;
  localparam int ATT_W     = 15;
  localparam int ATT_RW    = D2_W + 4;
  localparam int ATT_SCALE = 10;

endpackage : ppdm_pkg

`default_nettype wire

// ===== rtl/point_pair_distance_metrics.sv =====
// Pipelined Euclidean, Manhattan and ATT distances for a pair of points.
//
// The block takes one point pair per cycle while the output is not stalled
// and returns its three distances from the last stage. Three stages form the
// absolute differences, their squares and the squared distance; then one stage
// per result bit runs the Euclidean square root (25 stages), while the ATT
// distance, one more than the largest t with 10*t*t below the squared distance
// (zero for identical points), is searched bit by bit in the first 15 of those
// stages. A stall on a valid output freezes the whole pipeline, so a waiting
// result never blocks the next transaction from entering once the output is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "point_pair_distance_metrics_assert.svh"

module point_pair_distance_metrics
  import ppdm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_W-1:0] in_first_x,
  input  wire logic signed [COORD_W-1:0] in_first_y,
  input  wire logic signed [COORD_W-1:0] in_second_x,
  input  wire logic signed [COORD_W-1:0] in_second_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [EUC_W-1:0]               out_euclid_dist,
  output logic [MANH_W-1:0]              out_manhattan_dist,
  output logic [ATT_W-1:0]               out_att_dist
);

  logic                  adv;

  logic                  v1_r, v2_r;
  logic [COORD_W-1:0]    adx_r, ady_r, adx_nxt, ady_nxt;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [MANH_W-1:0]     manh2_r;
  logic                  zero2_r;

  logic                  vld_r   [0:EUC_W];
  logic [RAD_W-1:0]      erem_r  [0:EUC_W];
  logic [RAD_W-1:0]      erem_nxt[0:EUC_W];
  logic [EUC_W-1:0]      eroot_r [0:EUC_W];
  logic [EUC_W-1:0]      eroot_nxt[0:EUC_W];
  logic [MANH_W-1:0]     manh_r  [0:EUC_W];
  logic [ATT_W-1:0]      att_r   [0:EUC_W];
  logic [ATT_W-1:0]      att_nxt [0:EUC_W];
  logic [ATT_RW-1:0]     arem_r  [0:ATT_W];
  logic [ATT_RW-1:0]     arem_nxt[0:ATT_W];
  logic                  zero_r  [0:ATT_W];

  assign adv       = !(vld_r[EUC_W] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[EUC_W];

  assign out_euclid_dist    = eroot_r[EUC_W];
  assign out_manhattan_dist = manh_r[EUC_W];
  assign out_att_dist       = att_r[EUC_W];

  always_comb begin
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    dx = {in_first_x[COORD_W-1], in_first_x} - {in_second_x[COORD_W-1], in_second_x};
    dy = {in_first_y[COORD_W-1], in_first_y} - {in_second_y[COORD_W-1], in_second_y};
    adx_nxt = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady_nxt = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r   <= adx_nxt;
      ady_r   <= ady_nxt;
      sqx_r   <= SQ_W'(adx_r) * SQ_W'(adx_r);
      sqy_r   <= SQ_W'(ady_r) * SQ_W'(ady_r);
      manh2_r <= {1'b0, adx_r} + {1'b0, ady_r};
      zero2_r <= (adx_r == '0) && (ady_r == '0);
    end
  end

  always_comb begin
    logic [RAD_W-1:0]  trial;
    logic [ATT_RW-1:0] delta;
    logic [D2_W-1:0]   d2;
    logic [D2_W-1:0]   dm1;
    int                k;

    d2  = {1'b0, sqx_r} + {1'b0, sqy_r};
    dm1 = {1'b0, sqx_r} + {1'b0, sqy_r} - D2_W'(1);

    erem_nxt[0]  = RAD_W'(d2) << (2 * FRAC_BITS);
    eroot_nxt[0] = '0;
    att_nxt[0]   = '0;
    arem_nxt[0]  = zero2_r ? '0 : ATT_RW'(dm1);

    for (int j = 0; j < EUC_W; j++) begin
      k     = EUC_W - 1 - j;
      trial = (RAD_W'(eroot_r[j]) << (k + 1)) + (RAD_W'(1) << (2 * k));
      if (erem_r[j] >= trial) begin
        erem_nxt[j+1]  = erem_r[j] - trial;
        eroot_nxt[j+1] = eroot_r[j] | (EUC_W'(1) << k);
      end else begin
        erem_nxt[j+1]  = erem_r[j];
        eroot_nxt[j+1] = eroot_r[j];
      end
    end

    for (int j = 0; j < EUC_W; j++) begin
      if (j < ATT_W) begin
        k     = ATT_W - 1 - j;
        delta = (ATT_RW'(att_r[j]) << (k + 4)) + (ATT_RW'(att_r[j]) << (k + 2))
              + (ATT_RW'(ATT_SCALE) << (2 * k));
        if (delta <= arem_r[j]) begin
          arem_nxt[j+1] = arem_r[j] - delta;
          att_nxt[j+1]  = att_r[j] | (ATT_W'(1) << k);
        end else begin
          arem_nxt[j+1] = arem_r[j];
          att_nxt[j+1]  = att_r[j];
        end
      end else if (j == ATT_W) begin
        att_nxt[j+1] = zero_r[ATT_W] ? '0 : att_r[j] + ATT_W'(1);
      end else begin
        att_nxt[j+1] = att_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= EUC_W; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= v2_r;
      for (int j = 1; j <= EUC_W; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      manh_r[0] <= manh2_r;
      zero_r[0] <= zero2_r;
      for (int j = 0; j <= EUC_W; j++) begin
        erem_r[j]  <= erem_nxt[j];
        eroot_r[j] <= eroot_nxt[j];
        att_r[j]   <= att_nxt[j];
      end
      for (int j = 1; j <= EUC_W; j++) begin
        manh_r[j] <= manh_r[j-1];
      end
      for (int j = 0; j <= ATT_W; j++) begin
        arem_r[j] <= arem_nxt[j];
      end
      for (int j = 1; j <= ATT_W; j++) begin
        zero_r[j] <= zero_r[j-1];
      end
    end
  end

  `PPDM_ASSERT_NXT(a_freeze_holds, !adv, $stable(vld_r[EUC_W]) && $stable(eroot_r[EUC_W]), "Frozen pipeline changed its output.")
  `PPDM_ASSERT_IMP(a_zero_consistent, out_valid, (out_euclid_dist == '0) == (out_att_dist == '0), "Euclidean and ATT distances disagree on a zero distance.")
  `PPDM_ASSERT_IMP(a_euclid_bound, out_valid, 64'(out_euclid_dist) <= (64'(out_manhattan_dist) << FRAC_BITS), "Euclidean distance exceeds the Manhattan distance.")
  `PPDM_ASSERT_IMP(a_att_zero, vld_r[ATT_W] && zero_r[ATT_W], att_nxt[ATT_W+1] == '0,
                   "ATT distance of identical points is not zero.")

endmodule : point_pair_distance_metrics

`default_nettype wire
